/* rtl/core/bblru_pkg.sv */
// ----------------------------------------------------------------------------
// bblru_pkg: shared types and constants of the byte budget LRU cache
// Field widths, action and register codes, sequencer states and the
// command that the sequencer broadcasts to the row of entry cells.
// ----------------------------------------------------------------------------
package bblru_pkg;

  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_PORT_W   = 64;
  localparam int DATA_W       = 32;
  localparam int BYTES_W      = 40;
  localparam int CNT_W        = 6;
  localparam int CFG_IDX_W    = 2;

  // Action codes of an input beat.
  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_TRIM   = 2'd3
  } act_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ITEMS = 2'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_EVICT,
    S_INS,
    S_FINAL
  } state_t;

  // Operation applied by all cells in the same cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_TOUCH,
    OP_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
  } cell_ctl_t;

endpackage

/* rtl/core/bblru_cell.sv */
// ----------------------------------------------------------------------------
// bblru_cell: one entry of the recency ordered row
// Holds key, value and size of the entry at its place in the row. Place 0
// is the least recently used entry. Entries shift down from the upper
// neighbor on removal and touch, and the broadcast entry is written in.
// ----------------------------------------------------------------------------
module bblru_cell
  import bblru_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] lookup_key,
  input  logic [KEY_BITS-1:0] bc_key,
  input  logic [DATA_W-1:0]   bc_value,
  input  logic [DATA_W-1:0]   bc_size,
  input  logic [KEY_BITS-1:0] up_key,
  input  logic [DATA_W-1:0]   up_value,
  input  logic [DATA_W-1:0]   up_size,
  output logic [KEY_BITS-1:0] key,
  output logic [DATA_W-1:0]   value,
  output logic [DATA_W-1:0]   size,
  output logic                match
);

  localparam logic [CNT_W:0] PLACE = (CNT_W+1)'(IDX);

  logic [KEY_BITS-1:0] key_r;
  logic [DATA_W-1:0]   value_r;
  logic [DATA_W-1:0]   size_r;
  logic                take_up;
  logic                take_bc;
  logic [CNT_W:0]      pos_x;
  logic [CNT_W:0]      cnt_x;

  assign pos_x = {1'b0, ctl.pos};
  assign cnt_x = {1'b0, ctl.cnt};

  // The cell is occupied when its place lies below the entry count.
  assign match = (PLACE < cnt_x) && (key_r == lookup_key);

  // Decide where the next contents come from.
  always_comb begin
    take_up = 1'b0;
    take_bc = 1'b0;
    case (ctl.op)
      OP_REMOVE: begin
        take_up = (PLACE >= pos_x) && (PLACE < cnt_x);
      end
      OP_TOUCH: begin
        take_up = (PLACE >= pos_x) && (PLACE + 1'b1 < cnt_x);
        take_bc = (PLACE + 1'b1 == cnt_x);
      end
      OP_WRITE: begin
        take_bc = (PLACE == cnt_x);
      end
      default: begin
        take_up = 1'b0;
        take_bc = 1'b0;
      end
    endcase
  end

  // Entry storage, no reset: occupancy follows from the count.
  always_ff @(posedge clk) begin
    if (take_bc) begin
      key_r   <= bc_key;
      value_r <= bc_value;
      size_r  <= bc_size;
    end else if (take_up) begin
      key_r   <= up_key;
      value_r <= up_value;
      size_r  <= up_size;
    end
  end

  assign key   = key_r;
  assign value = value_r;
  assign size  = size_r;

endmodule

/* rtl/core/byte_budget_lru_cache.sv */
// ----------------------------------------------------------------------------
// byte_budget_lru_cache: LRU cache of keyed entries under a byte budget
// Top level: sequencer, counters, configuration and result register
// around a row of entry cells kept in recency order.
// ----------------------------------------------------------------------------
// One input beat is handled at a time. A find or an erase passes through the
// steps accept, tag compare across all cells, action and final, where the
// final result beat is sent. A trim adds the eviction check, and an insert
// adds the eviction check and the write. Every entry evicted to fit the byte
// budget is one more pass of the eviction check: each such removal shifts the
// whole row down by one place and sends its own beat. The removal of an entry
// with the same key is done in the action step, and the eviction forced by a
// full row in the eviction check. A stalled result channel holds the
// sequencer when it has a beat to send. Configuration writes are always taken.
module byte_budget_lru_cache
  import bblru_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [KEY_PORT_W-1:0] in_key,
  input  logic [DATA_W-1:0]     in_value_handle,
  input  logic [DATA_W-1:0]     in_size_bytes,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_removal,
  output logic [KEY_PORT_W-1:0] out_key_out,
  output logic [DATA_W-1:0]     out_value_out,
  output logic                  out_hit,
  output logic [BYTES_W-1:0]    out_used_bytes_now,
  output logic [CNT_W-1:0]      out_entry_count,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTES_W-1:0]    cfg_data
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  state_t               state_r, state_nxt;
  act_t                 act_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_W-1:0]    val_r;
  logic [DATA_W-1:0]    size_r;
  logic                 hit_r;
  logic [CNT_W-1:0]     hpos_r;
  logic [DATA_W-1:0]    hval_r;
  logic [DATA_W-1:0]    hsize_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [BYTES_W-1:0]   used_r, used_nxt;
  logic [BYTES_W-1:0]   cap_r;
  logic [CNT_W-1:0]     min_r;

  logic                 out_valid_r;
  logic                 out_is_removal_r;
  logic [KEY_PORT_W-1:0] out_key_r;
  logic [DATA_W-1:0]    out_value_r;
  logic                 out_hit_r;
  logic [BYTES_W-1:0]   out_used_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_last_r;

  cell_ctl_t            ctl;
  logic [KEY_BITS-1:0]  bc_key;
  logic [DATA_W-1:0]    bc_value;
  logic [DATA_W-1:0]    bc_size;

  logic [KEY_BITS-1:0]  c_key   [ENTRIES+1];
  logic [DATA_W-1:0]    c_value [ENTRIES+1];
  logic [DATA_W-1:0]    c_size  [ENTRIES+1];
  logic [ENTRIES-1:0]   c_match;

  logic                 m_hit;
  logic [CNT_W-1:0]     m_pos;
  logic [DATA_W-1:0]    m_val;
  logic [DATA_W-1:0]    m_size;

  logic                 emit_ok;
  logic                 emit;
  logic                 e_removal;
  logic [KEY_PORT_W-1:0] e_key;
  logic [DATA_W-1:0]    e_value;
  logic                 e_hit;
  logic                 e_last;

  logic                 over;
  logic                 evict_bytes;
  logic                 do_evict;
  logic [BYTES_W:0]     demand;

  // ---------------------------------------------------------------- cells
  assign c_key[ENTRIES]   = '0;
  assign c_value[ENTRIES] = '0;
  assign c_size[ENTRIES]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bblru_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lookup_key (key_r),
      .bc_key     (bc_key),
      .bc_value   (bc_value),
      .bc_size    (bc_size),
      .up_key     (c_key[g+1]),
      .up_value   (c_value[g+1]),
      .up_size    (c_size[g+1]),
      .key        (c_key[g]),
      .value      (c_value[g]),
      .size       (c_size[g]),
      .match      (c_match[g])
    );
  end

  // Collapse the one-hot match into place, value and size.
  always_comb begin
    m_pos  = '0;
    m_val  = '0;
    m_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_match[i]) begin
        m_pos  = m_pos | CNT_W'(i);
        m_val  = m_val | c_value[i];
        m_size = m_size | c_size[i];
      end
    end
  end
  assign m_hit = |c_match;

  // ------------------------------------------------------- shared conditions
  assign emit_ok = !out_valid_r || out_ready;
  assign demand  = {1'b0, used_r} +
                   ((act_r == ACT_INSERT) ? (BYTES_W+1)'(size_r) : '0);
  assign over        = demand > {1'b0, cap_r};
  assign evict_bytes = (cnt_r != '0) && (cnt_r > min_r) && over;
  assign do_evict    = evict_bytes || ((act_r == ACT_INSERT) && (cnt_r == FULL));

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        case (act_r)
          ACT_FIND:  state_nxt = S_FINAL;
          ACT_TRIM:  state_nxt = S_EVICT;
          ACT_ERASE: begin
            if (!hit_r || emit_ok) state_nxt = S_FINAL;
          end
          default: begin
            if (!hit_r || emit_ok) state_nxt = S_EVICT;
          end
        endcase
      end
      S_EVICT: begin
        if (do_evict) begin
          if (emit_ok && !evict_bytes) state_nxt = S_INS;
        end else begin
          state_nxt = (act_r == ACT_INSERT) ? S_INS : S_FINAL;
        end
      end
      S_INS: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (emit_ok) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ctl.op    = OP_HOLD;
    ctl.pos   = hpos_r;
    ctl.cnt   = cnt_r;
    bc_key    = key_r;
    bc_value  = hval_r;
    bc_size   = hsize_r;
    emit      = 1'b0;
    e_removal = 1'b1;
    e_key     = KEY_PORT_W'(key_r);
    e_value   = hval_r;
    e_hit     = 1'b0;
    e_last    = 1'b0;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    case (state_r)
      S_ACT: begin
        if (hit_r && (act_r == ACT_FIND)) begin
          ctl.op = OP_TOUCH;
        end else if (hit_r && emit_ok &&
                     ((act_r == ACT_ERASE) || (act_r == ACT_INSERT))) begin
          ctl.op   = OP_REMOVE;
          emit     = 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          used_nxt = (used_r >= BYTES_W'(hsize_r)) ? used_r - BYTES_W'(hsize_r) : '0;
        end
      end
      S_EVICT: begin
        if (do_evict && emit_ok) begin
          ctl.op   = OP_REMOVE;
          ctl.pos  = '0;
          emit     = 1'b1;
          e_key    = KEY_PORT_W'(c_key[0]);
          e_value  = c_value[0];
          cnt_nxt  = cnt_r - 1'b1;
          used_nxt = (used_r >= BYTES_W'(c_size[0])) ? used_r - BYTES_W'(c_size[0]) : '0;
        end
      end
      S_INS: begin
        ctl.op   = OP_WRITE;
        bc_value = val_r;
        bc_size  = size_r;
        cnt_nxt  = cnt_r + 1'b1;
        used_nxt = used_r + BYTES_W'(size_r);
      end
      S_FINAL: begin
        emit      = emit_ok;
        e_removal = 1'b0;
        e_last    = 1'b1;
        e_hit     = hit_r && (act_r != ACT_TRIM);
        e_value   = (hit_r && ((act_r == ACT_FIND) || (act_r == ACT_ERASE))) ?
                    hval_r : '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // ------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      used_r      <= '0;
      cap_r       <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      if (cfg_valid && (cfg_index == CFG_CAPACITY)) cap_r <= cfg_data;
      if (cfg_valid && (cfg_index == CFG_MIN_ITEMS)) min_r <= cfg_data[CNT_W-1:0];
      if (emit_ok) out_valid_r <= emit;
    end
  end

  // Request capture and match results.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= act_t'(in_action);
      key_r  <= in_key[KEY_BITS-1:0];
      val_r  <= in_value_handle;
      size_r <= in_size_bytes;
    end
    if (state_r == S_MATCH) begin
      hit_r   <= m_hit;
      hpos_r  <= m_pos;
      hval_r  <= m_val;
      hsize_r <= m_size;
    end
  end

  // Result register; counts are taken after this beat's effect.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_is_removal_r <= e_removal;
      out_key_r        <= e_key;
      out_value_r      <= e_value;
      out_hit_r        <= e_hit;
      out_used_r       <= used_nxt;
      out_cnt_r        <= cnt_nxt;
      out_last_r       <= e_last;
    end
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_is_removal     = out_is_removal_r;
  assign out_key_out        = out_key_r;
  assign out_value_out      = out_value_r;
  assign out_hit            = out_hit_r;
  assign out_used_bytes_now = out_used_r;
  assign out_entry_count    = out_cnt_r;
  assign out_last           = out_last_r;

  // ------------------------------------------------------------ assertions
  // The entry count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("entry count above capacity");

  // An insert write always finds a free cell.
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> cnt_r < FULL) else $error("insert into full row");

  // A removal beat takes exactly one entry out of the row.
  a_remove_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_removal) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("removal without count drop");

  // A final beat is sent only from the final state.
  a_final_src: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_last) |-> state_r == S_FINAL) else $error("stray final beat");

endmodule
